>>> rtl/bpl_pkg.sv
// Shared constants and types for the block peak limiter.
// No dependencies; used by every module of the block.
`default_nettype none

package bpl_pkg;

  // Field and datapath widths
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned OUT_W    = 18;
  localparam int unsigned DIV_W    = 23;
  localparam int unsigned STEP_W   = 16;
  localparam int unsigned QUO_W    = 17;

  // Block size default
  localparam int unsigned BLOCK_SAMPLES_DEF = 64;

  // Unity gain in Q16 and the largest peak magnitude
  localparam logic [DIV_W-1:0]  UNITY    = DIV_W'(65536);
  localparam logic [DIV_W-1:0]  PEAK_MAX = {DIV_W{1'b1}};
  localparam logic [STEP_W-1:0] STEP_RST = STEP_W'(655);

  // One finished block handed from front to queue
  typedef struct packed {
    logic             valid;
    logic [DIV_W-1:0] divisor;
    logic             active;
  } push_t;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
    logic wr_bank;
  } qstat_t;

  // Oldest pending block seen by the back
  typedef struct packed {
    logic             valid;
    logic             bank;
    logic [DIV_W-1:0] divisor;
    logic             active;
  } head_t;

endpackage

`default_nettype wire

>>> rtl/bpl_front.sv
// Front end: accepts samples, tracks the block peak, updates the divisor.
// Depends on bpl_pkg; feeds bpl_queue and the sample memory in bpl_back.
`default_nettype none

module bpl_front #(
  parameter int unsigned BLOCK_SAMPLES = bpl_pkg::BLOCK_SAMPLES_DEF,
  parameter int unsigned IDX_W         = $clog2(BLOCK_SAMPLES)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic signed [bpl_pkg::SAMPLE_W-1:0] sample_in_i,
  input  wire logic                         release_step_we_i,
  input  wire logic [bpl_pkg::STEP_W-1:0]   release_step_i,
  input  wire bpl_pkg::qstat_t              qstat_i,
  output logic                              busy_o,
  output logic                              mem_we_o,
  output logic [IDX_W:0]                    mem_addr_o,
  output logic [bpl_pkg::SAMPLE_W-1:0]      mem_data_o,
  output bpl_pkg::push_t                    push_o
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCK_SAMPLES - 1);

  logic [IDX_W-1:0]             fill_q, fill_d;
  logic [bpl_pkg::DIV_W-1:0]    peak_q, peak_d;
  logic [bpl_pkg::DIV_W-1:0]    div_q, div_d;
  logic                         act_q, act_d;
  logic [bpl_pkg::STEP_W-1:0]   step_q;
  logic                         accept;
  logic                         last;
  logic [bpl_pkg::SAMPLE_W-1:0] abs_s;
  logic [bpl_pkg::DIV_W-1:0]    mag;
  logic [bpl_pkg::DIV_W-1:0]    blk_peak;
  logic [bpl_pkg::DIV_W-1:0]    excess;

  assign busy_o = qstat_i.full;
  assign accept = start_i && !qstat_i.full;
  assign last   = (fill_q == LAST_IDX);

  // Magnitude of the sample, most negative value saturated
  always_comb begin
    abs_s = sample_in_i[bpl_pkg::SAMPLE_W-1] ? (~sample_in_i + 1'b1) : sample_in_i;
    mag   = abs_s[bpl_pkg::SAMPLE_W-1] ? bpl_pkg::PEAK_MAX : abs_s[bpl_pkg::DIV_W-1:0];
    blk_peak = (mag > peak_q) ? mag : peak_q;
    excess   = div_q - bpl_pkg::UNITY;
  end

  // Sample store write
  assign mem_we_o   = accept;
  assign mem_addr_o = {qstat_i.wr_bank, fill_q};
  assign mem_data_o = sample_in_i;

  // Fill and peak update per accepted sample; divisor update at block end
  always_comb begin
    fill_d = fill_q;
    peak_d = peak_q;
    div_d  = div_q;
    act_d  = act_q;
    if (accept) begin
      if (last) begin
        fill_d = '0;
        peak_d = '0;
        if (blk_peak > div_q) begin
          div_d = blk_peak;
          act_d = 1'b1;
        end else if (div_q > bpl_pkg::UNITY) begin
          if (excess > bpl_pkg::DIV_W'(step_q)) begin
            div_d = div_q - bpl_pkg::DIV_W'(step_q);
          end else begin
            div_d = bpl_pkg::UNITY;
            act_d = 1'b0;
          end
        end
      end else begin
        fill_d = fill_q + 1'b1;
        peak_d = blk_peak;
      end
    end
  end

  assign push_o.valid   = accept && last;
  assign push_o.divisor = div_d;
  assign push_o.active  = act_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      peak_q <= '0;
      div_q  <= bpl_pkg::UNITY;
      act_q  <= 1'b0;
      step_q <= bpl_pkg::STEP_RST;
    end else begin
      fill_q <= fill_d;
      peak_q <= peak_d;
      div_q  <= div_d;
      act_q  <= act_d;
      if (release_step_we_i) begin
        step_q <= release_step_i;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/bpl_queue.sv
// Two-entry queue of finished blocks; entry index doubles as memory bank.
// Depends on bpl_pkg; sits between bpl_front and bpl_back.
`default_nettype none

module bpl_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire bpl_pkg::push_t push_i,
  input  wire logic           pop_i,
  output bpl_pkg::qstat_t     qstat_o,
  output bpl_pkg::head_t      head_o
);

  logic [bpl_pkg::DIV_W-1:0] div_q [2];
  logic                      act_q [2];
  logic                      wr_ptr_q, rd_ptr_q;
  logic [1:0]                count_q, count_d;

  assign qstat_o.full    = (count_q == 2'd2);
  assign qstat_o.wr_bank = wr_ptr_q;

  assign head_o.valid   = (count_q != 2'd0);
  assign head_o.bank    = rd_ptr_q;
  assign head_o.divisor = div_q[rd_ptr_q];
  assign head_o.active  = act_q[rd_ptr_q];

  // Occupancy
  always_comb begin
    count_d = count_q;
    if (push_i.valid && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push_i.valid && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i.valid) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // Entry payload
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      div_q[wr_ptr_q] <= push_i.divisor;
      act_q[wr_ptr_q] <= push_i.active;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bpl_back.sv
// Back end: holds the two-bank sample memory and divides each sample
// by the block divisor with a restoring divider. Depends on bpl_pkg.
`default_nettype none

module bpl_back #(
  parameter int unsigned BLOCK_SAMPLES = bpl_pkg::BLOCK_SAMPLES_DEF,
  parameter int unsigned IDX_W         = $clog2(BLOCK_SAMPLES)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         mem_we_i,
  input  wire logic [IDX_W:0]               mem_addr_i,
  input  wire logic [bpl_pkg::SAMPLE_W-1:0] mem_data_i,
  input  wire bpl_pkg::head_t               head_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  output logic signed [bpl_pkg::OUT_W-1:0]  sample_out_o,
  output logic                              limiting_o,
  output logic                              block_end_o
);

  localparam int unsigned MEM_DEPTH = 2 * (2 ** IDX_W);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCK_SAMPLES - 1);
  localparam int unsigned CNT_W = $clog2(bpl_pkg::QUO_W);
  localparam logic [CNT_W-1:0] CNT_START = CNT_W'(bpl_pkg::QUO_W - 1);
  localparam logic [bpl_pkg::QUO_W-1:0] Q_MAX = bpl_pkg::QUO_W'(65536);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SETUP,
    S_DIV
  } state_e;

  logic [bpl_pkg::SAMPLE_W-1:0] mem [MEM_DEPTH];
  logic [bpl_pkg::SAMPLE_W-1:0] rd_data_q;

  state_e                       state_q;
  logic [IDX_W-1:0]             k_q;
  logic [CNT_W-1:0]             cnt_q;
  logic                         neg_q;
  logic [bpl_pkg::DIV_W-1:0]    rem_q;
  logic [bpl_pkg::QUO_W-1:0]    dvd_q;
  logic [bpl_pkg::QUO_W-1:0]    quo_q;
  logic                         strobe_q;
  logic signed [bpl_pkg::OUT_W-1:0] res_q;
  logic                         lim_q;
  logic                         end_q;

  logic [bpl_pkg::SAMPLE_W-1:0] abs_s;
  logic [bpl_pkg::DIV_W:0]      rsh;
  logic [bpl_pkg::DIV_W:0]      rdiff;
  logic                         ge;
  logic [bpl_pkg::DIV_W-1:0]    rem_d;
  logic [bpl_pkg::QUO_W-1:0]    quo_d;
  logic [bpl_pkg::QUO_W-1:0]    quo_sat;
  logic [bpl_pkg::OUT_W-1:0]    res_mag;
  logic                         done;

  // Sample memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we_i) begin
      mem[mem_addr_i] <= mem_data_i;
    end
    rd_data_q <= mem[{head_i.bank, k_q}];
  end

  // One restoring division step
  always_comb begin
    abs_s   = rd_data_q[bpl_pkg::SAMPLE_W-1] ? (~rd_data_q + 1'b1) : rd_data_q;
    rsh     = {rem_q, dvd_q[bpl_pkg::QUO_W-1]};
    rdiff   = rsh - {1'b0, head_i.divisor};
    ge      = (rsh >= {1'b0, head_i.divisor});
    rem_d   = ge ? rdiff[bpl_pkg::DIV_W-1:0] : rsh[bpl_pkg::DIV_W-1:0];
    quo_d   = {quo_q[bpl_pkg::QUO_W-2:0], ge};
    quo_sat = (quo_d > Q_MAX) ? Q_MAX : quo_d;
    res_mag = {1'b0, quo_sat};
    done    = (state_q == S_DIV) && (cnt_q == '0);
  end

  assign pop_o = done && (k_q == LAST_IDX);

  // Sequencer and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      k_q      <= '0;
      cnt_q    <= '0;
      neg_q    <= 1'b0;
      rem_q    <= '0;
      dvd_q    <= '0;
      quo_q    <= '0;
      res_q    <= '0;
      strobe_q <= 1'b0;
      end_q    <= 1'b0;
      lim_q    <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (head_i.valid) begin
            state_q <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_SETUP;
        end
        S_SETUP: begin
          // quotient fits 17 bits, so the top bits of the dividend seed the remainder
          neg_q   <= rd_data_q[bpl_pkg::SAMPLE_W-1];
          rem_q   <= abs_s[bpl_pkg::SAMPLE_W-1:1];
          dvd_q   <= {abs_s[0], {(bpl_pkg::QUO_W-1){1'b0}}};
          quo_q   <= '0;
          cnt_q   <= CNT_START;
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q <= rem_d;
          dvd_q <= {dvd_q[bpl_pkg::QUO_W-2:0], 1'b0};
          quo_q <= quo_d;
          cnt_q <= cnt_q - 1'b1;
          if (done) begin
            strobe_q <= 1'b1;
            res_q    <= neg_q ? -$signed(res_mag) : $signed(res_mag);
            lim_q    <= head_i.active;
            end_q    <= (k_q == LAST_IDX);
            if (k_q == LAST_IDX) begin
              k_q     <= '0;
              state_q <= S_IDLE;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= S_READ;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = strobe_q;
  assign sample_out_o = res_q;
  assign limiting_o   = lim_q;
  assign block_end_o  = end_q;

endmodule

`default_nettype wire

>>> rtl/block_peak_limiter_core.sv
// Block peak limiter. Samples enter at one per cycle while a buffer bank is free.
// Each result passes through read, setup and a 17-step divider; blocks that queue up
// are separated by one pass through the idle state. With the back end idle, a block's
// first result strobes once idle, read, setup and the divider follow its last sample.
// Two banks: busy is high only while both hold blocks not yet fully emitted.
// Results cannot be stalled. Reset clears control state; the memory is not cleared.
`default_nettype none

module block_peak_limiter_core #(
  parameter int unsigned BLOCK_SAMPLES = bpl_pkg::BLOCK_SAMPLES_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic signed [bpl_pkg::SAMPLE_W-1:0] sample_in_i,
  input  wire logic                                release_step_we_i,
  input  wire logic [bpl_pkg::STEP_W-1:0]          release_step_i,
  output logic                                     out_valid_o,
  output logic signed [bpl_pkg::OUT_W-1:0]         sample_out_o,
  output logic                                     limiting_o,
  output logic                                     block_end_o
);

  localparam int unsigned IDX_W = $clog2(BLOCK_SAMPLES);

  logic                         mem_we;
  logic [IDX_W:0]               mem_addr;
  logic [bpl_pkg::SAMPLE_W-1:0] mem_data;
  bpl_pkg::push_t               push;
  bpl_pkg::qstat_t              qstat;
  bpl_pkg::head_t               head;
  logic                         pop;

  bpl_front #(
    .BLOCK_SAMPLES(BLOCK_SAMPLES),
    .IDX_W        (IDX_W)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .sample_in_i      (sample_in_i),
    .release_step_we_i(release_step_we_i),
    .release_step_i   (release_step_i),
    .qstat_i          (qstat),
    .busy_o           (busy_o),
    .mem_we_o         (mem_we),
    .mem_addr_o       (mem_addr),
    .mem_data_o       (mem_data),
    .push_o           (push)
  );

  bpl_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .qstat_o(qstat),
    .head_o (head)
  );

  bpl_back #(
    .BLOCK_SAMPLES(BLOCK_SAMPLES),
    .IDX_W        (IDX_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mem_we_i    (mem_we),
    .mem_addr_i  (mem_addr),
    .mem_data_i  (mem_data),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .sample_out_o(sample_out_o),
    .limiting_o  (limiting_o),
    .block_end_o (block_end_o)
  );

endmodule

`default_nettype wire

>>> rtl/bpl_checker.sv
// Port-level checks for the block peak limiter, bound to the top level.
// Depends on bpl_pkg for field widths.
`default_nettype none

module bpl_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                start_i,
  input wire logic                                busy_o,
  input wire logic                                out_valid_o,
  input wire logic signed [bpl_pkg::OUT_W-1:0]    sample_out_o,
  input wire logic                                limiting_o,
  input wire logic                                block_end_o
);

  // Results are spaced by the divider, never in adjacent cycles
  a_strobe_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |=> !out_valid_o)
    else $error("results in adjacent cycles");

  // Limited output stays within full scale
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((sample_out_o <= 18'sd65536) && (sample_out_o >= -18'sd65536)))
    else $error("sample_out beyond full scale");

  // Busy only rises right after an item was taken
  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy rose without an accepted item");

  // Limiting holds across one block: it may change only after a block end
  a_lim_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !block_end_o) |=> ##18 (!out_valid_o || (limiting_o == $past(limiting_o, 19))))
    else $error("limiting changed inside a block");

endmodule

bind block_peak_limiter_core bpl_checker u_bpl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .out_valid_o (out_valid_o),
  .sample_out_o(sample_out_o),
  .limiting_o  (limiting_o),
  .block_end_o (block_end_o)
);

`default_nettype wire
